FILE: rtl/ev_pack_can_frame_decoder_assert.svh
// Assertion macros for the battery-pack CAN frame decoder.
`ifndef EV_PACK_CAN_FRAME_DECODER_ASSERT_SVH
`define EV_PACK_CAN_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset
`define EVPK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("evpk check failed");
// Next-cycle implication, held off during reset
`define EVPK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("evpk check failed");
`else
`define EVPK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define EVPK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/evpk_pkg.sv
// Shared types, constants and functions of the battery-pack CAN frame decoder.
package evpk_pkg;

	// Frame identifiers
	localparam logic [28:0] ID_VOLT = 29'h0F8;
	localparam logic [28:0] ID_CRC  = 29'h36C;
	localparam logic [28:0] ID_CELL = 29'h4DB;
	localparam logic [28:0] ID_DIAG = 29'h18DAF1DB;

	localparam int NUM_ALIVE = 29;
	localparam logic [28:0] ALIVE_IDS [NUM_ALIVE] = '{
		29'h381, 29'h382, 29'h387, 29'h388, 29'h3EF,
		29'h4AE, 29'h4AF, 29'h5A1, 29'h5AC, 29'h5AD, 29'h5B4, 29'h5B5, 29'h5B7,
		29'h5C9, 29'h5CB, 29'h5CC, 29'h5D6, 29'h5D7, 29'h5D9, 29'h5DC, 29'h5DD,
		29'h5EA, 29'h5ED, 29'h5F0, 29'h5F1, 29'h5F2, 29'h5F4, 29'h5F7, 29'h612
	};

	localparam logic [7:0]  CRC_POLY = 8'h1D;
	localparam logic [12:0] CELL_OFS = 13'd1000;

	// Register reset values
	localparam logic [7:0]  STARTUP_FRAMES_RST = 8'd50;
	localparam logic [7:0]  CRC_XOR_RST        = 8'h01;
	localparam logic [12:0] PACK_V_RST         = 13'd8191;
	localparam logic [12:0] CELL_RST           = 13'd5095;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STARTUP_FRAMES = 1'b0,
		CFG_CRC_XOR        = 1'b1
	} cfg_idx_t;

	// Stream widths
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 3;

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Frame class found by the front
	typedef enum logic [2:0] {
		K_OTHER,
		K_VOLT,
		K_CRC,
		K_CELL,
		K_DIAG,
		K_ALIVE
	} kind_t;

	// Classified item handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic       crc_bad;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
	} evpk_item_t;

	// CRC8 update by one byte, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d);
		logic [7:0] c;
		c = c_in ^ d;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

FILE: rtl/evpk_front.sv
// Front end: unpacks an incoming frame, classifies its ID and checks the CRC of an ID_CRC frame.
module evpk_front
	import evpk_pkg::*;
(
	input  logic [IN_DATA_W-1:0] frame,    // frame_id, data_byte_0 .. data_byte_7
	input  logic [7:0]           crc_xor,
	output evpk_item_t           item
);

	logic [28:0] id;
	logic [7:0]  b [8];
	logic [7:0]  crc;
	logic        list_hit;

	// Field unpack
	always_comb begin
		id = frame[28:0];
		for (int i = 0; i < 8; i++) begin
			b[i] = frame[29 + 8*i +: 8];
		end
	end

	// CRC over bytes 0..6
	always_comb begin
		crc = 8'h00;
		for (int i = 0; i < 7; i++) begin
			crc = crc8_byte(crc, b[i]);
		end
	end

	// Known-alive ID lookup, parallel compare
	always_comb begin
		list_hit = 1'b0;
		for (int i = 0; i < NUM_ALIVE; i++) begin
			list_hit = list_hit | (id == ALIVE_IDS[i]);
		end
	end

	// Classify
	always_comb begin
		item.b0      = b[0];
		item.b1      = b[1];
		item.b2      = b[2];
		item.b3      = b[3];
		item.crc_bad = 1'b0;
		priority if (id == ID_VOLT) begin
			item.kind = K_VOLT;
		end else if (id == ID_CRC) begin
			item.kind    = K_CRC;
			item.crc_bad = ((crc ^ crc_xor) != b[7]);
		end else if (id == ID_CELL) begin
			item.kind = K_CELL;
		end else if (id == ID_DIAG) begin
			item.kind = K_DIAG;
		end else if (list_hit) begin
			item.kind = K_ALIVE;
		end else begin
			item.kind = K_OTHER;
		end
	end

endmodule

FILE: rtl/evpk_queue.sv
// Short FIFO of classified items between front and back.
module evpk_queue
	import evpk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  evpk_item_t push_item,
	input  logic       pop,
	output evpk_item_t head_item,
	output logic       not_empty,
	output logic       full
);

	evpk_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign head_item = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == QCNT_W'(QDEPTH));

	// Storage, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/evpk_back.sv
// Back end: applies a classified item to the pack state and registers the result.
module evpk_back
	import evpk_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            startup_frames,
	input  logic                  q_valid,
	input  evpk_item_t            q_item,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // error_count, interlock_word, pack_voltage_dv,
	                                         // max_cell_mv, min_cell_mv, startup_done
	output logic [OUT_USER_W-1:0] m_tuser    // alive, forward_diag, crc_bad
);

	logic [7:0]  cnt_q;
	logic [15:0] interlock_q;
	logic [12:0] pack_v_q;
	logic [12:0] max_cell_q;
	logic [12:0] min_cell_q;
	logic [15:0] err_q;

	logic [7:0]  cnt_d;
	logic [15:0] interlock_d;
	logic [12:0] pack_v_d;
	logic [12:0] max_cell_d;
	logic [12:0] min_cell_d;
	logic [15:0] err_d;
	logic        alive_d;
	logic        fwd_d;
	logic        bad_d;
	logic [8:0]  cnt_next;
	logic        cnt_hit;

	assign pop = q_valid && (!m_tvalid || m_tready);

	assign cnt_next = {1'b0, cnt_q} + 9'd1;
	assign cnt_hit  = (cnt_next >= {1'b0, startup_frames});

	// Next state for the item at the queue head
	always_comb begin
		cnt_d       = cnt_q;
		interlock_d = interlock_q;
		pack_v_d    = pack_v_q;
		max_cell_d  = max_cell_q;
		min_cell_d  = min_cell_q;
		err_d       = err_q;
		alive_d     = 1'b0;
		fwd_d       = 1'b0;
		bad_d       = 1'b0;
		unique case (q_item.kind)
			K_VOLT: begin
				if (cnt_hit) begin
					cnt_d       = startup_frames;
					alive_d     = 1'b1;
					interlock_d = {q_item.b0, q_item.b1};
					pack_v_d    = {q_item.b2, q_item.b3[7:3]};
				end else begin
					cnt_d = cnt_next[7:0];
				end
			end
			K_CRC: begin
				alive_d = 1'b1;
				bad_d   = q_item.crc_bad;
				err_d   = err_q + {15'd0, q_item.crc_bad};
			end
			K_CELL: begin
				alive_d    = 1'b1;
				max_cell_d = {1'b0, q_item.b0, q_item.b1[7:4]} + CELL_OFS;
				min_cell_d = {1'b0, q_item.b1[3:0], q_item.b2} + CELL_OFS;
			end
			K_DIAG: begin
				alive_d = 1'b1;
				fwd_d   = 1'b1;
			end
			K_ALIVE: begin
				alive_d = 1'b1;
			end
			K_OTHER: begin
			end
			default: begin
			end
		endcase
	end

	// Pack state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			interlock_q <= '0;
			pack_v_q    <= PACK_V_RST;
			max_cell_q  <= CELL_RST;
			min_cell_q  <= CELL_RST;
			err_q       <= '0;
		end else if (pop) begin
			cnt_q       <= cnt_d;
			interlock_q <= interlock_d;
			pack_v_q    <= pack_v_d;
			max_cell_q  <= max_cell_d;
			min_cell_q  <= min_cell_d;
			err_q       <= err_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (pop) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata <= {(cnt_d >= startup_frames), min_cell_d, max_cell_d, pack_v_d,
				interlock_d, err_d};
			m_tuser <= {bad_d, fwd_d, alive_d};
		end
	end

endmodule

FILE: rtl/ev_pack_can_frame_decoder.sv
// Battery-pack CAN frame decoder, top level.
// From input item accepted to result valid: queue write, then output register; a stalled result holds it in the queue.
// One item per cycle while m_tready holds; the back end updates the pack state once per popped item.
// The 2-entry queue lets input accept while a result waits on the output side.
// Reset (arst_n low, asynchronous): config registers, output valid and pack state to reset values, queue empty.
`include "ev_pack_can_frame_decoder_assert.svh"

module ev_pack_can_frame_decoder
	import evpk_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [7:0]            cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // frame_id, data_byte_0 .. data_byte_7
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // error_count, interlock_word, pack_voltage_dv,
	                                         // max_cell_mv, min_cell_mv, startup_done
	output logic [OUT_USER_W-1:0] m_tuser    // alive, forward_diag, crc_bad
);

	logic [7:0] startup_frames_q;
	logic [7:0] crc_xor_q;
	evpk_item_t front_item;
	evpk_item_t head_item;
	logic       q_push;
	logic       q_pop;
	logic       q_valid;
	logic       q_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_frames_q <= STARTUP_FRAMES_RST;
			crc_xor_q        <= CRC_XOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_STARTUP_FRAMES: startup_frames_q <= cfg_data;
				CFG_CRC_XOR:        crc_xor_q        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	evpk_front u_front (
		.frame   (s_tdata),
		.crc_xor (crc_xor_q),
		.item    (front_item)
	);

	evpk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.pop       (q_pop),
		.head_item (head_item),
		.not_empty (q_valid),
		.full      (q_full)
	);

	evpk_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.startup_frames (startup_frames_q),
		.q_valid        (q_valid),
		.q_item         (head_item),
		.pop            (q_pop),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser)
	);

	// A full queue only happens behind a stalled result
	`EVPK_ASSERT_IMPLIES(a_full_needs_stall, clk, arst_n, q_full, m_tvalid)
	// A failed CRC item bumps the error count by one
	`EVPK_ASSERT_NEXT(a_err_bump, clk, arst_n, q_pop && head_item.crc_bad, m_tdata[15:0] == $past(m_tdata[15:0]) + 16'd1 || !$past(m_tvalid))
	// A diagnostic reply is always an alive frame
	`EVPK_ASSERT_IMPLIES(a_diag_alive, clk, arst_n, m_tvalid && m_tuser[1], m_tuser[0])

endmodule
